// ===== design/atd_pkg.sv =====
// atd_pkg: shared constants and types for the averaged temperature block.
// Depends on nothing; used by the interfaces, the divider and the top level.
package atd_pkg;

  // Field widths fixed by the register map and the result format
  localparam int LEN_W      = 6;
  localparam int CAL_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int TEMP_W     = 14;
  localparam int CHAR_W     = 6;
  localparam int BCD_W      = 16;
  localparam int BCD_CNT_W  = $clog2(TEMP_W + 1);
  localparam int DIV_STEP_W = 5;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_AVG_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_30  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_110 = 2'd2;

  // Register reset values
  localparam logic [LEN_W-1:0] AVG_LEN_RST = 6'd1;
  localparam logic [CAL_W-1:0] CAL_30_RST  = 12'd1760;
  localparam logic [CAL_W-1:0] CAL_110_RST = 12'd1320;

  // Operation codes
  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Calibration arithmetic in hundredths of a degree
  localparam int SPAN_HUNDREDTHS  = 8000;
  localparam int BASE_HUNDREDTHS  = 3000;
  localparam int LIMIT_HUNDREDTHS = 10000;
  localparam logic [TEMP_W-1:0] TOP_HUNDREDTHS = 14'd9999;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Control from the sequencer to the shared divider
  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_ctrl_t;

endpackage

// ===== design/atd_if.sv =====
// atd_if: valid/ready channel interfaces for request, result and register writes.
// Depends on atd_pkg for field widths.

interface atd_req_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [SAMPLE_BITS-1:0] sample_code;

  modport source (output valid, operation, sample_code, input ready);
  modport sink   (input valid, operation, sample_code, output ready);
endinterface

interface atd_rsp_if ();
  logic                          valid;
  logic                          ready;
  logic [atd_pkg::TEMP_W-1:0]    temp_hundredths;
  logic [atd_pkg::CHAR_W-1:0]    tens_char;
  logic [atd_pkg::CHAR_W-1:0]    units_char;
  logic [atd_pkg::CHAR_W-1:0]    tenths_char;
  logic [atd_pkg::CHAR_W-1:0]    hundredths_char;
  logic                          out_of_range;

  modport source (output valid, temp_hundredths, tens_char, units_char, tenths_char,
                  hundredths_char, out_of_range, input ready);
  modport sink   (input valid, temp_hundredths, tens_char, units_char, tenths_char,
                  hundredths_char, out_of_range, output ready);
endinterface

interface atd_cfg_if ();
  logic                             valid;
  logic                             ready;
  logic [atd_pkg::CFG_IDX_W-1:0]    index;
  logic [atd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/atd_div.sv =====
// atd_div: shared restoring divider, one quotient bit per cycle.
// Depends on atd_pkg (div_ctrl_t). Caller guarantees rem_init < divisor.
module atd_div #(
  parameter int DIV_W = 12,
  parameter int QB    = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  atd_pkg::div_ctrl_t   ctrl,
  input  logic [DIV_W-1:0]     rem_init,
  input  logic [DIV_W-1:0]     divisor,
  input  logic [QB-1:0]        low,
  output logic                 busy,
  output logic [QB-1:0]        quotient
);

  logic [DIV_W-1:0]               rem;
  logic [DIV_W-1:0]               dvs;
  logic [QB-1:0]                  qr;
  logic [atd_pkg::DIV_STEP_W-1:0] cnt;
  logic [DIV_W:0]                 trial;
  logic [DIV_W:0]                 trial_sub;
  logic                           fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial     = {rem, qr[QB-1]};
    trial_sub = trial - {1'b0, dvs};
    fits      = (trial >= {1'b0, dvs});
  end

  // Count the remaining steps
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.start) begin
      cnt <= ctrl.steps;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Advance partial remainder and quotient
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= rem_init;
      dvs <= divisor;
      qr  <= low;
    end else if (cnt != '0) begin
      rem <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      qr  <= {qr[QB-2:0], fits};
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = qr;

endmodule

// ===== design/averaged_temperature_to_decimal.sv =====
// averaged_temperature_to_decimal: sample ring, averaging, two-point calibration
// and decimal conversion. Depends on atd_pkg, atd_if and atd_div.
//
//   channel  dir  handshake         payload
//   req      in   valid / ready     operation, sample_code
//   rsp      out  valid / ready     temp_hundredths, four ASCII digits, out_of_range
//   cfg      in   valid / ready=1   index, data
//
// A store request is taken while idle and leaves the sequencer idle. A report
// request runs ring reads over the averaging length, the average divide, the
// calibration multiplies and the range compare, the temperature divide, binary
// to BCD conversion and a load of the output register. A clamped result skips
// the temperature divide; equal calibration points go straight to BCD.
// Reset is synchronous; it clears the write position, the ring valid bits and
// the output valid flag, returns the sequencer to idle and loads the register
// reset values. A finished result waits in the output register; store requests
// are still taken meanwhile, and a next report holds at its end until it drains.
module averaged_temperature_to_decimal #(
  parameter int RING_DEPTH  = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic      clk,
  input  logic      rst,
  atd_req_if.sink   req,
  atd_rsp_if.source rsp,
  atd_cfg_if.sink   cfg
);

  localparam int AW     = $clog2(RING_DEPTH);
  localparam int NW     = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + AW;
  localparam int OPW    = (SAMPLE_BITS >= atd_pkg::CAL_W) ? SAMPLE_BITS : atd_pkg::CAL_W;
  localparam int NUM_W  = OPW + atd_pkg::TEMP_W;
  localparam int NUM_SW = NUM_W + 1;
  localparam int DIV_W  = (OPW >= NW) ? OPW : NW;
  localparam int QB     = (SAMPLE_BITS >= atd_pkg::TEMP_W) ? SAMPLE_BITS : atd_pkg::TEMP_W;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SUM       = 4'd1;
  localparam logic [3:0] ST_DIV1_GO   = 4'd2;
  localparam logic [3:0] ST_DIV1_WAIT = 4'd3;
  localparam logic [3:0] ST_MUL_A     = 4'd4;
  localparam logic [3:0] ST_MUL_B     = 4'd5;
  localparam logic [3:0] ST_MUL_C     = 4'd6;
  localparam logic [3:0] ST_CHECK     = 4'd7;
  localparam logic [3:0] ST_DIV2_GO   = 4'd8;
  localparam logic [3:0] ST_DIV2_WAIT = 4'd9;
  localparam logic [3:0] ST_BCD       = 4'd10;
  localparam logic [3:0] ST_DONE      = 4'd11;

  // Configuration registers
  logic [atd_pkg::LEN_W-1:0] avg_len;
  logic [atd_pkg::CAL_W-1:0] cal_30;
  logic [atd_pkg::CAL_W-1:0] cal_110;

  // Sequencer and ring state
  logic [3:0]             state;
  logic [AW-1:0]          wp;
  logic [AW-1:0]          wp_inc;
  logic [AW-1:0]          rd_ptr;
  logic [NW-1:0]          issue_left;
  logic [NW-1:0]          n_len;
  logic [NW-1:0]          n_eff;
  logic                   rd_pend;
  logic [RING_DEPTH-1:0]  ring_valid;
  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   rd_data_valid;
  logic [SUM_W-1:0]       sum;

  // Arithmetic registers
  logic [NUM_SW-1:0]      acc;
  logic [NUM_W-1:0]       lim;
  logic [atd_pkg::TEMP_W-1:0]    temp;
  logic [atd_pkg::TEMP_W-1:0]    bin;
  logic [atd_pkg::BCD_W-1:0]     bcd;
  logic [atd_pkg::BCD_W-1:0]     bcd_adj;
  logic [atd_pkg::BCD_CNT_W-1:0] bcd_cnt;
  logic                          flag;

  // Output register
  logic                          out_valid;
  logic [atd_pkg::TEMP_W-1:0]    out_temp;
  logic [atd_pkg::BCD_W-1:0]     out_bcd;
  logic                          out_flag;

  // Divider hookup
  atd_pkg::div_ctrl_t div_ctrl;
  logic [DIV_W-1:0]   div_rem_init;
  logic [DIV_W-1:0]   div_divisor;
  logic [QB-1:0]      div_low;
  logic               div_busy;
  logic [QB-1:0]      div_q;

  // Calibration operands
  logic [OPW-1:0]    avg_w;
  logic [OPW-1:0]    c30_w;
  logic [OPW-1:0]    c110_w;
  logic              cal_neg;
  logic              cal_equal;
  logic [OPW-1:0]    sden;
  logic [OPW:0]      sdiff;
  logic [NUM_SW-1:0] sdiff_ext;

  logic req_fire;
  logic rsp_fire;
  logic out_free;

  assign req_fire = req.valid && req.ready;
  assign rsp_fire = out_valid && rsp.ready;
  assign out_free = !out_valid || rsp.ready;
  assign wp_inc   = (wp == AW'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;

  // Clamp the averaging length into 1..RING_DEPTH
  always_comb begin
    priority if (avg_len == '0) begin
      n_eff = NW'(1);
    end else if (int'(avg_len) > RING_DEPTH) begin
      n_eff = NW'(RING_DEPTH);
    end else begin
      n_eff = NW'(avg_len);
    end
  end

  // Form calibration operands, ordered so the span is positive
  always_comb begin
    avg_w     = OPW'(div_q[SAMPLE_BITS-1:0]);
    c30_w     = OPW'(cal_30);
    c110_w    = OPW'(cal_110);
    cal_neg   = (cal_110 < cal_30);
    cal_equal = (cal_110 == cal_30);
    sden      = cal_neg ? (c30_w - c110_w) : (c110_w - c30_w);
    sdiff     = cal_neg ? ({1'b0, c30_w} - {1'b0, avg_w}) : ({1'b0, avg_w} - {1'b0, c30_w});
    sdiff_ext = {{(NUM_SW - OPW - 1){sdiff[OPW]}}, sdiff};
  end

  // Select divider operands for the average or the temperature
  always_comb begin
    div_ctrl.start = 1'b0;
    div_ctrl.steps = atd_pkg::DIV_STEP_W'(SAMPLE_BITS);
    div_rem_init   = DIV_W'(sum[SUM_W-1:SAMPLE_BITS]);
    div_divisor    = DIV_W'(n_len);
    div_low        = QB'(sum[SAMPLE_BITS-1:0]) << (QB - SAMPLE_BITS);
    if (state == ST_DIV1_GO) begin
      div_ctrl.start = 1'b1;
    end else if (state == ST_DIV2_GO) begin
      div_ctrl.start = 1'b1;
      div_ctrl.steps = atd_pkg::DIV_STEP_W'(atd_pkg::TEMP_W);
      div_rem_init   = DIV_W'(acc[NUM_W-1:atd_pkg::TEMP_W]);
      div_divisor    = DIV_W'(sden);
      div_low        = QB'(acc[atd_pkg::TEMP_W-1:0]) << (QB - atd_pkg::TEMP_W);
    end
  end

  atd_div #(
    .DIV_W (DIV_W),
    .QB    (QB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .rem_init (div_rem_init),
    .divisor  (div_divisor),
    .low      (div_low),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Add three to every BCD digit above four before the shift
  always_comb begin
    for (int i = 0; i < atd_pkg::BCD_W / 4; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  // Take register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_len <= atd_pkg::AVG_LEN_RST;
      cal_30  <= atd_pkg::CAL_30_RST;
      cal_110 <= atd_pkg::CAL_110_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        atd_pkg::REG_AVG_LEN: avg_len <= cfg.data[atd_pkg::LEN_W-1:0];
        atd_pkg::REG_CAL_30:  cal_30  <= cfg.data[atd_pkg::CAL_W-1:0];
        atd_pkg::REG_CAL_110: cal_110 <= cfg.data[atd_pkg::CAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring memory: write on a store request, registered read at the walk pointer
  always_ff @(posedge clk) begin
    if (req_fire && (req.operation == atd_pkg::OP_STORE)) begin
      ring[wp_inc] <= req.sample_code;
    end
    rd_data <= ring[rd_ptr];
  end

  // Sequencer and ring control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      wp            <= '0;
      ring_valid    <= '0;
      rd_pend       <= 1'b0;
      rd_data_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rd_data_valid <= ring_valid[rd_ptr];
      // Hold the finished result until the sink takes it
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            if (req.operation == atd_pkg::OP_STORE) begin
              wp                 <= wp_inc;
              ring_valid[wp_inc] <= 1'b1;
            end else if (cal_equal) begin
              state <= ST_BCD;
            end else begin
              state <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          rd_pend <= (issue_left != '0);
          if (issue_left == '0) begin
            state <= ST_DIV1_GO;
          end
        end
        ST_DIV1_GO:   state <= ST_DIV1_WAIT;
        ST_DIV1_WAIT: if (!div_busy) state <= ST_MUL_A;
        ST_MUL_A:     state <= ST_MUL_B;
        ST_MUL_B:     state <= ST_MUL_C;
        ST_MUL_C:     state <= ST_CHECK;
        ST_CHECK: begin
          if (acc[NUM_SW-1] || (acc[NUM_W-1:0] >= lim)) begin
            state <= ST_BCD;
          end else begin
            state <= ST_DIV2_GO;
          end
        end
        ST_DIV2_GO:   state <= ST_DIV2_WAIT;
        ST_DIV2_WAIT: if (!div_busy) state <= ST_BCD;
        ST_BCD:       if (bcd_cnt == atd_pkg::BCD_CNT_W'(1)) state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath: walk, accumulate, calibrate, clamp and convert
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        rd_ptr     <= wp;
        issue_left <= n_eff;
        n_len      <= n_eff;
        sum        <= '0;
        temp       <= '0;
        bin        <= '0;
        bcd        <= '0;
        bcd_cnt    <= atd_pkg::BCD_CNT_W'(atd_pkg::TEMP_W);
        flag       <= cal_equal;
      end
      ST_SUM: begin
        if (issue_left != '0) begin
          issue_left <= issue_left - 1'b1;
          rd_ptr     <= (rd_ptr == '0) ? AW'(RING_DEPTH - 1) : rd_ptr - 1'b1;
        end
        if (rd_pend && rd_data_valid) begin
          sum <= sum + SUM_W'(rd_data);
        end
      end
      ST_MUL_A: acc <= NUM_SW'(sdiff_ext * NUM_SW'(atd_pkg::SPAN_HUNDREDTHS));
      ST_MUL_B: acc <= acc + NUM_SW'(NUM_SW'(sden) * NUM_SW'(atd_pkg::BASE_HUNDREDTHS));
      ST_MUL_C: lim <= NUM_W'(NUM_W'(sden) * NUM_W'(atd_pkg::LIMIT_HUNDREDTHS));
      ST_CHECK: begin
        if (acc[NUM_SW-1]) begin
          flag <= 1'b1;
        end else if (acc[NUM_W-1:0] >= lim) begin
          temp <= atd_pkg::TOP_HUNDREDTHS;
          bin  <= atd_pkg::TOP_HUNDREDTHS;
          flag <= 1'b1;
        end
      end
      ST_DIV2_WAIT: begin
        temp <= div_q[atd_pkg::TEMP_W-1:0];
        bin  <= div_q[atd_pkg::TEMP_W-1:0];
      end
      ST_BCD: begin
        bcd     <= {bcd_adj[atd_pkg::BCD_W-2:0], bin[atd_pkg::TEMP_W-1]};
        bin     <= {bin[atd_pkg::TEMP_W-2:0], 1'b0};
        bcd_cnt <= bcd_cnt - 1'b1;
      end
      default: ;
    endcase
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_temp <= temp;
      out_bcd  <= bcd;
      out_flag <= flag;
    end
  end

  assign req.ready           = (state == ST_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.temp_hundredths = out_temp;
  assign rsp.tens_char       = atd_pkg::ASCII_ZERO + atd_pkg::CHAR_W'(out_bcd[15:12]);
  assign rsp.units_char      = atd_pkg::ASCII_ZERO + atd_pkg::CHAR_W'(out_bcd[11:8]);
  assign rsp.tenths_char     = atd_pkg::ASCII_ZERO + atd_pkg::CHAR_W'(out_bcd[7:4]);
  assign rsp.hundredths_char = atd_pkg::ASCII_ZERO + atd_pkg::CHAR_W'(out_bcd[3:0]);
  assign rsp.out_of_range    = out_flag;

endmodule
